FILE: rtl/core/xtea_pkg.sv
package xtea_pkg;

	localparam int unsigned WORD_W         = 32;
	localparam int unsigned ROUND_W        = 7;
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned MAX_ROUNDS_DEF = 64;

	localparam logic [WORD_W-1:0]  DELTA          = 32'h9E37_79B9;
	localparam logic [ROUND_W-1:0] ROUND_COUNT_RST = 7'd64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 3'd4;

	typedef enum logic {
		OP_ENCIPHER = 1'b0,
		OP_DECIPHER = 1'b1
	} op_t;

	typedef struct packed {
		op_t               req_type;
		logic [WORD_W-1:0] data_low;
		logic [WORD_W-1:0] data_high;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_low;
		logic [WORD_W-1:0] result_high;
	} rsp_t;

	// Working state of one block as it moves down the pipeline.
	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] v0;
		logic [WORD_W-1:0] v1;
		logic [WORD_W-1:0] sum;
	} stage_t;

	// The XTEA mixing function: ((x << 4) ^ (x >> 5)) + x, xored with sum + key.
	function automatic logic [WORD_W-1:0] mix_half(
		input logic [WORD_W-1:0] x,
		input logic [WORD_W-1:0] sum_key
	);
		logic [WORD_W-1:0] f;
		f = ((x << 4) ^ (x >> 5)) + x;
		return f ^ sum_key;
	endfunction

endpackage

FILE: rtl/core/xtea_block_cipher.sv
// XTEA cipher, fully unrolled: one 64-bit block per cycle, encipher or decipher chosen
// per beat. A block is taken at every clock edge where start is high; busy is always low.
// Each result passes one entry stage plus one register stage per Feistel half-round and
// is flagged by done for exactly one cycle. The receiver cannot stall, so results must
// be taken as they come. A round_count below MAX_ROUNDS makes the unused stages pass
// the block through; latency does not change. Keys and round_count must be written
// only while no block is in flight.
module xtea_block_cipher
	import xtea_pkg::*;
#(
	parameter int unsigned MAX_ROUNDS = MAX_ROUNDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	output logic                 done,
	output rsp_t                 result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_wdata
);

	localparam int unsigned NSTAGE  = 2 * MAX_ROUNDS;
	localparam int unsigned LATENCY = NSTAGE + 1;

	logic [WORD_W-1:0]  key_q [4];
	logic [ROUND_W-1:0] round_count_q;
	logic [ROUND_W-1:0] n_eff;

	stage_t pipe_s [NSTAGE+1];
	logic   vld_s  [NSTAGE+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0]      <= '0;
			key_q[1]      <= '0;
			key_q[2]      <= '0;
			key_q[3]      <= '0;
			round_count_q <= ROUND_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY0:   key_q[0] <= cfg_wdata;
				REG_KEY1:   key_q[1] <= cfg_wdata;
				REG_KEY2:   key_q[2] <= cfg_wdata;
				REG_KEY3:   key_q[3] <= cfg_wdata;
				REG_ROUNDS: round_count_q <= cfg_wdata[ROUND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(round_count_q) > int'(MAX_ROUNDS)) begin
			n_eff = ROUND_W'(MAX_ROUNDS);
		end else begin
			n_eff = round_count_q;
		end
	end

	assign busy = 1'b0;

	// Entry stage: a decipher starts from delta times the round count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pipe_s[0].op  <= req.req_type;
			pipe_s[0].v0  <= req.data_low;
			pipe_s[0].v1  <= req.data_high;
			pipe_s[0].sum <= (req.req_type == OP_DECIPHER) ?
				DELTA * {{(WORD_W-ROUND_W){1'b0}}, n_eff} : '0;
		end
	end

	// Stage j does half-round j%2 of round j/2. In the first half an encipher updates v0
	// from v1, a decipher updates v1 from v0; the second half does the other one.
	for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
		localparam int unsigned RND   = j / 2;
		localparam bit          FIRST = (j % 2) == 0;

		logic              act;
		logic              src_v0;
		logic [WORD_W-1:0] src;
		logic [WORD_W-1:0] dst;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] mix;
		logic [WORD_W-1:0] dst_next;
		stage_t            nxt;

		always_comb begin
			act    = int'(n_eff) > int'(RND);
			src_v0 = (pipe_s[j].op == OP_DECIPHER) ? FIRST : !FIRST;
			src    = src_v0 ? pipe_s[j].v0 : pipe_s[j].v1;
			dst    = src_v0 ? pipe_s[j].v1 : pipe_s[j].v0;
			// The key word follows sum bits 12:11 when v0 feeds the mix, else bits 1:0.
			key    = src_v0 ? key_q[pipe_s[j].sum[12:11]] : key_q[pipe_s[j].sum[1:0]];
			mix    = mix_half(src, pipe_s[j].sum + key);
			dst_next = (pipe_s[j].op == OP_DECIPHER) ? dst - mix : dst + mix;

			nxt = pipe_s[j];
			if (act) begin
				if (src_v0) begin
					nxt.v1 = dst_next;
				end else begin
					nxt.v0 = dst_next;
				end
				if (FIRST) begin
					nxt.sum = (pipe_s[j].op == OP_DECIPHER) ?
						pipe_s[j].sum - DELTA : pipe_s[j].sum + DELTA;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (vld_s[j]) begin
				pipe_s[j+1] <= nxt;
			end
		end
	end

	assign done               = vld_s[NSTAGE];
	assign result.result_low  = pipe_s[NSTAGE].v0;
	assign result.result_high = pipe_s[NSTAGE].v1;

`ifndef SYNTHESIS
	// Every result beat goes back to exactly one command beat at a fixed distance.
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("done without a command at the pipeline latency");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted command produced no result");

	// With zero rounds every stage passes the block through.
	a_zero_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(done && n_eff == '0 && $past(vld_s[0], NSTAGE)) |->
			(result.result_low == $past(pipe_s[0].v0, NSTAGE) &&
			 result.result_high == $past(pipe_s[0].v1, NSTAGE)))
		else $error("zero-round block was altered");
`endif

endmodule
